FILE: sv/tcw_pkg.sv
`timescale 1ns / 1ps
// tcw_pkg: shared constants, opcodes, state and command types for the
// text cell terminal writer. No dependencies.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS_COUNT = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS_COUNT;

    localparam int COL_W     = $clog2(COLUMNS + 1);
    localparam int COL_IDX_W = $clog2(COLUMNS);
    localparam int ROW_W     = (ROWS_COUNT > 2) ? $clog2(ROWS_COUNT) : 1;
    localparam int ADDR_W    = $clog2(CELL_COUNT);

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [7:0] DEFAULT_FG   = 8'h0F;
    localparam logic [7:0] DEFAULT_BG   = 8'h00;
    localparam logic [7:0] CH_BLANK     = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;

    typedef enum logic [2:0] {
        OP_PUT_CHAR     = 3'd0,
        OP_MOVE_CURSOR  = 3'd1,
        OP_SET_COLOR    = 3'd2,
        OP_RESET_COLOR  = 3'd3,
        OP_CLEAR_TO_END = 3'd4,
        OP_CLEAR_LINE   = 3'd5,
        OP_CLEAR_SCREEN = 3'd6,
        OP_READ_CELL    = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_WRITE,
        ACT_CHAR,
        ACT_FILL,
        ACT_FILL_ALL,
        ACT_READ
    } act_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 do_scroll;
        logic [ROW_W-1:0]     scroll_row;
        act_t                 act;
        logic [ROW_W-1:0]     act_row;
        logic [COL_IDX_W-1:0] lo;
        logic [COL_IDX_W-1:0] hi;
        logic [7:0]           ch;
        logic [7:0]           fg;
        logic [7:0]           bg;
        logic [COL_W-1:0]     res_col;
        logic [ROW_W-1:0]     res_row;
    } cmd_t;

endpackage

FILE: sv/tcw_front.sv
`timescale 1ns / 1ps
// tcw_front: accepts words, tracks cursor, colors and the scroll base row,
// and turns each word into a grid command. Depends on tcw_pkg.
module tcw_front import tcw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_opcode,
    input  logic [7:0]           s_char_code,
    input  logic [7:0]           s_target_col,
    input  logic [7:0]           s_target_row,
    input  logic [7:0]           s_new_fg,
    input  logic [7:0]           s_new_bg,
    input  logic                 init_done,
    input  logic                 fifo_full,
    output logic                 push,
    output cmd_t                 push_cmd
);

    localparam logic [ROW_W-1:0]     ROW_LAST = ROW_W'(ROWS_COUNT - 1);
    localparam logic [COL_IDX_W-1:0] COL_LAST = COL_IDX_W'(COLUMNS - 1);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] base_reg, base_next;
    logic [7:0]       fg_reg, fg_next;
    logic [7:0]       bg_reg, bg_next;

    logic                 nl;
    logic [COL_W:0]       tab_sum;
    logic [COL_W:0]       tab_next;
    logic [COL_IDX_W-1:0] tcol_cl;
    logic [ROW_W-1:0]     trow_cl;
    logic [ROW_W-1:0]     lrow;
    logic [ROW_W:0]       psum;
    cmd_t                 cmd;

    assign s_ready  = init_done && !fifo_full;
    assign push     = s_valid && s_ready;
    assign push_cmd = cmd;

    assign tab_sum  = {1'b0, col_reg} + (COL_W + 1)'(4);
    assign tab_next = {tab_sum[COL_W:2], 2'b00};
    assign tcol_cl  = (int'(s_target_col) >= COLUMNS) ? COL_LAST : COL_IDX_W'(s_target_col);
    assign trow_cl  = (int'(s_target_row) >= ROWS_COUNT) ? ROW_LAST : ROW_W'(s_target_row);

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        fg_next   = fg_reg;
        bg_next   = bg_reg;
        nl        = 1'b0;
        cmd            = '0;
        cmd.act        = ACT_NONE;
        cmd.scroll_row = base_reg;
        cmd.lo         = '0;
        cmd.hi         = COL_LAST;
        cmd.ch         = CH_BLANK;
        cmd.fg         = fg_reg;
        cmd.bg         = bg_reg;
        case (op_t'(s_opcode))
            OP_PUT_CHAR: begin
                if (s_char_code == CH_NEWLINE) begin
                    nl       = 1'b1;
                    col_next = '0;
                end else if (s_char_code == CH_RETURN) begin
                    col_next = '0;
                end else if (s_char_code == CH_TAB) begin
                    if (int'(tab_next) >= COLUMNS) begin
                        nl       = 1'b1;
                        col_next = '0;
                    end else begin
                        col_next = COL_W'(tab_next);
                    end
                end else if (s_char_code == CH_BACKSPACE) begin
                    if (col_reg != '0) begin
                        col_next = col_reg - COL_W'(1);
                    end
                    cmd.act = ACT_CHAR;
                    cmd.lo  = COL_IDX_W'(col_next);
                    cmd.hi  = COL_IDX_W'(col_next);
                end else begin
                    cmd.act = ACT_WRITE;
                    cmd.ch  = s_char_code;
                    if (int'(col_reg) >= COLUMNS) begin
                        nl       = 1'b1;
                        cmd.lo   = '0;
                        cmd.hi   = '0;
                        col_next = COL_W'(1);
                    end else begin
                        cmd.lo   = COL_IDX_W'(col_reg);
                        cmd.hi   = COL_IDX_W'(col_reg);
                        col_next = col_reg + COL_W'(1);
                    end
                end
            end
            OP_MOVE_CURSOR: begin
                col_next = COL_W'(tcol_cl);
                row_next = trow_cl;
            end
            OP_SET_COLOR: begin
                fg_next = s_new_fg;
                bg_next = s_new_bg;
            end
            OP_RESET_COLOR: begin
                fg_next = DEFAULT_FG;
                bg_next = DEFAULT_BG;
            end
            OP_CLEAR_TO_END: begin
                if (int'(col_reg) < COLUMNS) begin
                    cmd.act = ACT_FILL;
                    cmd.lo  = COL_IDX_W'(col_reg);
                end
            end
            OP_CLEAR_LINE: begin
                cmd.act  = ACT_FILL;
                col_next = '0;
            end
            OP_CLEAR_SCREEN: begin
                cmd.act  = ACT_FILL_ALL;
                col_next = '0;
                row_next = '0;
            end
            OP_READ_CELL: begin
                cmd.act = ACT_READ;
                cmd.lo  = tcol_cl;
                cmd.hi  = tcol_cl;
            end
            default: begin
                cmd.act = ACT_NONE;
            end
        endcase
        if (nl) begin
            if (row_reg == ROW_LAST) begin
                cmd.do_scroll = 1'b1;
                base_next     = (base_reg == ROW_LAST) ? '0 : base_reg + ROW_W'(1);
            end else begin
                row_next = row_reg + ROW_W'(1);
            end
        end
        lrow = (op_t'(s_opcode) == OP_READ_CELL) ? trow_cl : row_next;
        psum = {1'b0, base_next} + {1'b0, lrow};
        if (int'(psum) >= ROWS_COUNT) begin
            psum = psum - (ROW_W + 1)'(ROWS_COUNT);
        end
        cmd.act_row = ROW_W'(psum);
        cmd.res_col = col_next;
        cmd.res_row = row_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
            fg_reg   <= DEFAULT_FG;
            bg_reg   <= DEFAULT_BG;
        end else if (push) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
            fg_reg   <= fg_next;
            bg_reg   <= bg_next;
        end
    end

endmodule

FILE: sv/tcw_fifo.sv
`timescale 1ns / 1ps
// tcw_fifo: short command queue between the front and the back part.
// Depends on tcw_pkg.
module tcw_fifo import tcw_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t             slots [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (int'(count_reg) == FIFO_DEPTH);
    assign head  = slots[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + (PTR_W + 1)'(1);
                2'b01:   count_reg <= count_reg - (PTR_W + 1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: sv/tcw_back.sv
`timescale 1ns / 1ps
// tcw_back: executes grid commands on the cell memories, runs the clearing
// pass after reset and holds the result register. Depends on tcw_pkg.
module tcw_back import tcw_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             head,
    input  logic             empty,
    output logic             pop,
    output logic             init_done,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [COL_W-1:0] m_cursor_col,
    output logic [ROW_W-1:0] m_cursor_row,
    output logic [7:0]       m_cell_char,
    output logic [7:0]       m_cell_fg,
    output logic [7:0]       m_cell_bg
);

    localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELL_COUNT - 1);

    logic [7:0] mem_chars [CELL_COUNT];
    logic [7:0] mem_fg    [CELL_COUNT];
    logic [7:0] mem_bg    [CELL_COUNT];

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [7:0]        wch_reg, wch_next;
    logic [7:0]        wfg_reg, wfg_next;
    logic [7:0]        wbg_reg, wbg_next;
    logic              wcol_reg, wcol_next;
    logic              pend_reg, pend_next;
    logic [7:0]        rd_char_reg, rd_fg_reg, rd_bg_reg;

    logic              m_valid_reg;
    logic [COL_W-1:0]  m_col_reg;
    logic [ROW_W-1:0]  m_row_reg;
    logic [7:0]        m_char_reg, m_fg_reg, m_bg_reg;

    logic              we_char, we_color;
    logic [7:0]        wr_char, wr_fg, wr_bg;
    logic              out_done, out_read;

    cmd_t              src;
    state_t            act_state;
    logic [ADDR_W-1:0] act_start, act_end, scroll_start;

    assign pop       = (state_reg == ST_IDLE) && !empty && !m_valid_reg;
    assign init_done = (state_reg != ST_INIT);
    assign src       = (state_reg == ST_IDLE) ? head : cmd_reg;

    assign act_start    = ADDR_W'(src.act_row) * ADDR_W'(COLUMNS) + ADDR_W'(src.lo);
    assign act_end      = act_start + ADDR_W'(src.hi) - ADDR_W'(src.lo);
    assign scroll_start = ADDR_W'(src.scroll_row) * ADDR_W'(COLUMNS);

    always_comb begin
        case (src.act)
            ACT_WRITE, ACT_CHAR, ACT_FILL, ACT_FILL_ALL: act_state = ST_FILL;
            ACT_READ: act_state = ST_READ;
            default:  act_state = ST_DONE;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (addr_reg == CELL_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    state_next = head.do_scroll ? ST_FILL : act_state;
                end
            end
            ST_FILL: begin
                if (addr_reg == end_reg) begin
                    state_next = pend_reg ? act_state : ST_DONE;
                end
            end
            ST_READ:      state_next = ST_READ_WAIT;
            ST_READ_WAIT: state_next = ST_IDLE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_INIT;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        we_char  = 1'b0;
        we_color = 1'b0;
        wr_char  = wch_reg;
        wr_fg    = wfg_reg;
        wr_bg    = wbg_reg;
        out_done = 1'b0;
        out_read = 1'b0;
        case (state_reg)
            ST_INIT: begin
                we_char  = 1'b1;
                we_color = 1'b1;
                wr_char  = CH_BLANK;
                wr_fg    = DEFAULT_FG;
                wr_bg    = DEFAULT_BG;
            end
            ST_FILL: begin
                we_char  = 1'b1;
                we_color = wcol_reg;
            end
            ST_READ_WAIT: out_read = 1'b1;
            ST_DONE:      out_done = 1'b1;
            default: begin
                we_char = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb begin
        cmd_next  = cmd_reg;
        addr_next = addr_reg;
        end_next  = end_reg;
        wch_next  = wch_reg;
        wfg_next  = wfg_reg;
        wbg_next  = wbg_reg;
        wcol_next = wcol_reg;
        pend_next = pend_reg;
        if (state_reg == ST_INIT) begin
            if (addr_reg != CELL_LAST) begin
                addr_next = addr_reg + ADDR_W'(1);
            end
        end else if (pop && head.do_scroll) begin
            cmd_next  = head;
            addr_next = scroll_start;
            end_next  = scroll_start + ADDR_W'(COLUMNS - 1);
            wch_next  = CH_BLANK;
            wfg_next  = DEFAULT_FG;
            wbg_next  = DEFAULT_BG;
            wcol_next = 1'b1;
            pend_next = 1'b1;
        end else if (pop || (state_reg == ST_FILL && addr_reg == end_reg && pend_reg)) begin
            if (pop) begin
                cmd_next = head;
            end
            pend_next = 1'b0;
            wch_next  = src.ch;
            wfg_next  = src.fg;
            wbg_next  = src.bg;
            wcol_next = (src.act != ACT_CHAR);
            if (src.act == ACT_FILL_ALL) begin
                addr_next = '0;
                end_next  = CELL_LAST;
            end else begin
                addr_next = act_start;
                end_next  = act_end;
            end
        end else if (state_reg == ST_FILL && addr_reg != end_reg) begin
            addr_next = addr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (we_char) begin
            mem_chars[addr_reg] <= wr_char;
        end
        if (we_color) begin
            mem_fg[addr_reg] <= wr_fg;
            mem_bg[addr_reg] <= wr_bg;
        end
        rd_char_reg <= mem_chars[addr_reg];
        rd_fg_reg   <= mem_fg[addr_reg];
        rd_bg_reg   <= mem_bg[addr_reg];
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        end_reg  <= end_next;
        wch_reg  <= wch_next;
        wfg_reg  <= wfg_next;
        wbg_reg  <= wbg_next;
        wcol_reg <= wcol_next;
        if (out_done || out_read) begin
            m_col_reg  <= cmd_reg.res_col;
            m_row_reg  <= cmd_reg.res_row;
            m_char_reg <= out_read ? rd_char_reg : 8'h00;
            m_fg_reg   <= out_read ? rd_fg_reg : 8'h00;
            m_bg_reg   <= out_read ? rd_bg_reg : 8'h00;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            addr_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            pend_reg  <= pend_next;
            if (out_done || out_read) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_cursor_col = m_col_reg;
    assign m_cursor_row = m_row_reg;
    assign m_cell_char  = m_char_reg;
    assign m_cell_fg    = m_fg_reg;
    assign m_cell_bg    = m_bg_reg;

    a_no_pop_in_init: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INIT |-> !pop)
        else $error("command taken during clearing pass");

    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        addr_reg <= CELL_LAST)
        else $error("cell address out of range");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE || state_reg == ST_READ_WAIT))
        else $error("result raised outside finishing state");

endmodule

FILE: sv/text_cell_terminal_writer_unit.sv
`timescale 1ns / 1ps
// text_cell_terminal_writer_unit: top level of the text cell terminal writer.
// Depends on tcw_pkg, tcw_front, tcw_fifo and tcw_back.
//
//   channel   direction   handshake            payload
//   s_        in          s_valid / s_ready    opcode, char, target col/row, colors
//   m_        out         m_valid / m_ready    cursor col/row, read cell char/fg/bg
//
// after reset a clearing pass over all 2000 cells runs; s_ready stays low during it
// in the back part a written character passes ST_FILL then ST_DONE, a read ST_READ then ST_READ_WAIT, others ST_DONE
// a scroll first blanks a row of 80 cells in ST_FILL, a line clear fills up to 80 cells, a screen clear 2000
// a 4-deep command queue lets the front take words while the back is busy
// the back starts a command only when the result register is empty
module text_cell_terminal_writer_unit import tcw_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [2:0]       s_opcode,
    input  logic [7:0]       s_char_code,
    input  logic [7:0]       s_target_col,
    input  logic [7:0]       s_target_row,
    input  logic [7:0]       s_new_fg,
    input  logic [7:0]       s_new_bg,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [COL_W-1:0] m_cursor_col,
    output logic [ROW_W-1:0] m_cursor_row,
    output logic [7:0]       m_cell_char,
    output logic [7:0]       m_cell_fg,
    output logic [7:0]       m_cell_bg
);

    logic init_done;
    logic fifo_full;
    logic fifo_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head;

    tcw_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_char_code  (s_char_code),
        .s_target_col (s_target_col),
        .s_target_row (s_target_row),
        .s_new_fg     (s_new_fg),
        .s_new_bg     (s_new_bg),
        .init_done    (init_done),
        .fifo_full    (fifo_full),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    tcw_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (fifo_empty),
        .full     (fifo_full)
    );

    tcw_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .empty        (fifo_empty),
        .pop          (pop),
        .init_done    (init_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cursor_col (m_cursor_col),
        .m_cursor_row (m_cursor_row),
        .m_cell_char  (m_cell_char),
        .m_cell_fg    (m_cell_fg),
        .m_cell_bg    (m_cell_bg)
    );

endmodule

FILE: tb/text_cell_terminal_writer_unit_checker.sv
`timescale 1ns / 1ps
// checker for the text cell terminal writer: watches both channels, keeps its own
// copy of the grid and cursor, and compares every result word. Depends on tcw_pkg.
module text_cell_terminal_writer_unit_checker import tcw_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [2:0]       s_opcode,
    input  logic [7:0]       s_char_code,
    input  logic [7:0]       s_target_col,
    input  logic [7:0]       s_target_row,
    input  logic [7:0]       s_new_fg,
    input  logic [7:0]       s_new_bg,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [COL_W-1:0] m_cursor_col,
    input  logic [ROW_W-1:0] m_cursor_row,
    input  logic [7:0]       m_cell_char,
    input  logic [7:0]       m_cell_fg,
    input  logic [7:0]       m_cell_bg,
    output int               fail_count,
    output int               pending_count
);
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       ch;
        logic [7:0]       fg;
        logic [7:0]       bg;
    } cursor_word_t;

    logic [7:0] scr_ch [CELL_COUNT];
    logic [7:0] scr_fg [CELL_COUNT];
    logic [7:0] scr_bg [CELL_COUNT];
    int         cur_col, cur_row;
    logic [7:0] pen_fg, pen_bg;
    cursor_word_t cursor_queue[$];

    function automatic int cell_at(int c, int r);
        if (c >= COLUMNS) c = COLUMNS - 1;
        if (r >= ROWS_COUNT) r = ROWS_COUNT - 1;
        return r * COLUMNS + c;
    endfunction

    task automatic paint(int first, int count, logic [7:0] c, logic [7:0] f, logic [7:0] b);
        for (int i = first; i < first + count && i < CELL_COUNT; i++) begin
            scr_ch[i] = c;
            scr_fg[i] = f;
            scr_bg[i] = b;
        end
    endtask

    task automatic line_feed();
        cur_col = 0;
        if (cur_row + 1 >= ROWS_COUNT) begin
            cur_row = ROWS_COUNT - 1;
            for (int i = 0; i < (ROWS_COUNT - 1) * COLUMNS; i++) begin
                scr_ch[i] = scr_ch[i + COLUMNS];
                scr_fg[i] = scr_fg[i + COLUMNS];
                scr_bg[i] = scr_bg[i + COLUMNS];
            end
            paint((ROWS_COUNT - 1) * COLUMNS, COLUMNS, CH_BLANK, DEFAULT_FG, DEFAULT_BG);
        end else begin
            cur_row++;
        end
    endtask

    task automatic write_char(logic [7:0] c);
        int nxt, ix;
        if (c == CH_NEWLINE) begin
            line_feed();
        end else if (c == CH_RETURN) begin
            cur_col = 0;
        end else if (c == CH_TAB) begin
            nxt = (cur_col + 4) & ~3;
            if (nxt >= COLUMNS) line_feed();
            else cur_col = nxt;
        end else if (c == CH_BACKSPACE) begin
            if (cur_col > 0) cur_col--;
            scr_ch[cell_at(cur_col, cur_row)] = CH_BLANK;
        end else begin
            if (cur_col >= COLUMNS) line_feed();
            ix = cell_at(cur_col, cur_row);
            scr_ch[ix] = c;
            scr_fg[ix] = pen_fg;
            scr_bg[ix] = pen_bg;
            cur_col++;
        end
    endtask

    task automatic predict_word();
        cursor_word_t w;
        int ix;
        w = '0;
        case (op_t'(s_opcode))
            OP_PUT_CHAR: write_char(s_char_code);
            OP_MOVE_CURSOR: begin
                cur_col = (s_target_col >= COLUMNS) ? COLUMNS - 1 : s_target_col;
                cur_row = (s_target_row >= ROWS_COUNT) ? ROWS_COUNT - 1 : s_target_row;
            end
            OP_SET_COLOR: begin
                pen_fg = s_new_fg;
                pen_bg = s_new_bg;
            end
            OP_RESET_COLOR: begin
                pen_fg = DEFAULT_FG;
                pen_bg = DEFAULT_BG;
            end
            OP_CLEAR_TO_END: begin
                if (cur_col < COLUMNS)
                    paint(cell_at(cur_col, cur_row), COLUMNS - cur_col, CH_BLANK, pen_fg, pen_bg);
            end
            OP_CLEAR_LINE: begin
                paint(cell_at(0, cur_row), COLUMNS, CH_BLANK, pen_fg, pen_bg);
                cur_col = 0;
            end
            OP_CLEAR_SCREEN: begin
                paint(0, CELL_COUNT, CH_BLANK, pen_fg, pen_bg);
                cur_col = 0;
                cur_row = 0;
            end
            default: begin
                ix = cell_at(s_target_col, s_target_row);
                w.ch = scr_ch[ix];
                w.fg = scr_fg[ix];
                w.bg = scr_bg[ix];
            end
        endcase
        w.col = cur_col[COL_W-1:0];
        w.row = cur_row[ROW_W-1:0];
        cursor_queue.push_back(w);
    endtask

    always @(posedge aclk) begin
        cursor_word_t exp_w, got;
        if (!aresetn) begin
            paint(0, CELL_COUNT, CH_BLANK, DEFAULT_FG, DEFAULT_BG);
            cur_col = 0;
            cur_row = 0;
            pen_fg = DEFAULT_FG;
            pen_bg = DEFAULT_BG;
            cursor_queue.delete();
            fail_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_cursor_col, m_cursor_row, m_cell_char, m_cell_fg, m_cell_bg};
                if (cursor_queue.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result word %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_w = cursor_queue.pop_front();
                    if (got !== exp_w) begin
                        if (fail_count < 10)
                            $display("mismatch: col %0d/%0d row %0d/%0d ch %h/%h fg %h/%h bg %h/%h",
                                     exp_w.col, got.col, exp_w.row, got.row, exp_w.ch, got.ch,
                                     exp_w.fg, got.fg, exp_w.bg, got.bg);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) predict_word();
        end
        pending_count = cursor_queue.size();
    end
endmodule

FILE: tb/text_cell_terminal_writer_unit_test.sv
`timescale 1ns / 1ps
// top of the text cell terminal writer testbench: clock, reset, stimulus and verdict.
// Depends on tcw_pkg, the block and text_cell_terminal_writer_unit_checker.
module text_cell_terminal_writer_unit_test;
    import tcw_pkg::*;

    logic             aclk, aresetn;
    logic             s_valid, s_ready, m_valid, m_ready;
    logic [2:0]       s_opcode;
    logic [7:0]       s_char_code, s_target_col, s_target_row, s_new_fg, s_new_bg;
    logic [COL_W-1:0] m_cursor_col;
    logic [ROW_W-1:0] m_cursor_row;
    logic [7:0]       m_cell_char, m_cell_fg, m_cell_bg;
    int               fail_count, pending_count;
    int               cycle_count;
    bit               calm_phase, hold_off;

    text_cell_terminal_writer_unit uut (.*);
    text_cell_terminal_writer_unit_checker chk (.*);

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 2_000_000) begin
                $display("text_cell_terminal_writer_unit verification failed");
                $finish;
            end
        end
    end

    // receiver: random stall bursts, one long hold-off
    initial begin
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (300) @(negedge aclk);
                hold_off = 0;
            end
            if (!calm_phase && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
            m_ready <= 1;
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom);
    endfunction

    task automatic send_word(op_t op, logic [7:0] ch, logic [7:0] tc, logic [7:0] tr,
                             logic [7:0] fg, logic [7:0] bg);
        if (!calm_phase && $urandom_range(0, 4) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid      <= 1;
        s_opcode     <= op;
        s_char_code  <= ch;
        s_target_col <= tc;
        s_target_row <= tr;
        s_new_fg     <= fg;
        s_new_bg     <= bg;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic random_word();
        int k;
        logic [7:0] ch;
        k = $urandom_range(0, 99);
        ch = rnd8();
        if (k < 15) ch = CH_NEWLINE;
        else if (k < 20) ch = CH_RETURN;
        else if (k < 26) ch = CH_TAB;
        else if (k < 32) ch = CH_BACKSPACE;
        if (k < 70) send_word(OP_PUT_CHAR, ch, rnd8(), rnd8(), rnd8(), rnd8());
        else if (k < 77)
            send_word(OP_MOVE_CURSOR, rnd8(), ($urandom_range(0, 3) == 0) ? rnd8()
                      : 8'($urandom_range(0, 79)), ($urandom_range(0, 3) == 0) ? rnd8()
                      : 8'($urandom_range(0, 24)), rnd8(), rnd8());
        else if (k < 81) send_word(OP_SET_COLOR, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
        else if (k < 83) send_word(OP_RESET_COLOR, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
        else if (k < 86) send_word(OP_CLEAR_TO_END, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
        else if (k < 88) send_word(OP_CLEAR_LINE, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
        else if (k < 89) send_word(OP_CLEAR_SCREEN, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
        else send_word(OP_READ_CELL, rnd8(), rnd8(), rnd8(), rnd8(), rnd8());
    endtask

    initial begin
        aresetn = 0;
        s_valid = 0;
        s_opcode = 0;
        s_char_code = 0;
        s_target_col = 0;
        s_target_row = 0;
        s_new_fg = 0;
        s_new_bg = 0;
        calm_phase = 0;
        hold_off = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: extremes, controls, wrap and scroll
        send_word(OP_SET_COLOR, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_PUT_CHAR, 8'h00, 0, 0, 0, 0);
        send_word(OP_PUT_CHAR, 8'hFF, 0, 0, 0, 0);
        send_word(OP_READ_CELL, 0, 8'h00, 8'h00, 0, 0);
        send_word(OP_READ_CELL, 0, 8'hFF, 8'hFF, 0, 0);
        send_word(OP_PUT_CHAR, CH_TAB, 0, 0, 0, 0);
        send_word(OP_PUT_CHAR, CH_BACKSPACE, 0, 0, 0, 0);
        send_word(OP_PUT_CHAR, CH_RETURN, 0, 0, 0, 0);
        send_word(OP_PUT_CHAR, CH_BACKSPACE, 0, 0, 0, 0);
        send_word(OP_MOVE_CURSOR, 0, 8'd78, 8'd3, 0, 0);
        send_word(OP_PUT_CHAR, 8'h41, 0, 0, 0, 0);
        send_word(OP_PUT_CHAR, 8'h42, 0, 0, 0, 0);
        send_word(OP_CLEAR_TO_END, 0, 0, 0, 0, 0);
        send_word(OP_PUT_CHAR, CH_BACKSPACE, 0, 0, 0, 0);
        send_word(OP_PUT_CHAR, 8'h43, 0, 0, 0, 0);
        send_word(OP_PUT_CHAR, 8'h44, 0, 0, 0, 0);
        send_word(OP_MOVE_CURSOR, 0, 8'd77, 8'hFF, 0, 0);
        send_word(OP_PUT_CHAR, CH_TAB, 0, 0, 0, 0);
        send_word(OP_PUT_CHAR, CH_NEWLINE, 0, 0, 0, 0);
        send_word(OP_SET_COLOR, 0, 0, 0, 8'h00, 8'h00);
        send_word(OP_CLEAR_LINE, 0, 0, 0, 0, 0);
        send_word(OP_READ_CELL, 0, 8'd5, 8'd24, 0, 0);
        send_word(OP_RESET_COLOR, 0, 0, 0, 0, 0);
        send_word(OP_CLEAR_SCREEN, 0, 0, 0, 0, 0);
        send_word(OP_READ_CELL, 0, 8'd79, 8'd23, 0, 0);

        hold_off = 1;
        for (int i = 0; i < 740; i++) begin
            if (i == 640) calm_phase = 1;
            random_word();
        end
        s_valid <= 0;
        while (pending_count != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) $display("text_cell_terminal_writer_unit verification clean");
        else $display("text_cell_terminal_writer_unit verification failed");
        $finish;
    end
endmodule
